// File: hdl/mrpt_pkg.sv
// Shared types and constants for the memory random pattern test core.
// No dependencies; imported by every module under hdl/.
package mrpt_pkg;

  localparam int WORD_INDEX_BITS = 28;
  localparam int COUNT_W         = 29;
  localparam int OFFSET_W        = 30;
  localparam int GEN_W           = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << WORD_INDEX_BITS;

  localparam logic [GEN_W-1:0] GEN_TOP   = 32'h8000_0000;
  localparam logic [GEN_W-1:0] GEN_TAPS  = 32'h0020_1051;
  localparam logic [GEN_W-1:0] GEN_RESET = 32'd123456;

  // request types on the input channel
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_FILL  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  // classified operations passed from front to back
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_STARTED  = 3'd0;
  localparam logic [2:0] KIND_WRITE    = 3'd1;
  localparam logic [2:0] KIND_MATCH    = 3'd2;
  localparam logic [2:0] KIND_PASS     = 3'd3;
  localparam logic [2:0] KIND_MISMATCH = 3'd4;
  localparam logic [2:0] KIND_IGNORED  = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] read_word;
  } req_t;

  typedef struct packed {
    logic [2:0]          result_kind;
    logic [OFFSET_W-1:0] byte_offset;
    logic [15:0]         write_word;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] read_word;
  } cmd_t;

endpackage

// File: hdl/mrpt_front.sv
// Front end: decodes incoming requests and holds them in a two-entry queue.
// Depends on mrpt_pkg.
module mrpt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mrpt_pkg::req_t req,
  output mrpt_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import mrpt_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       decoded;

  always_comb begin
    decoded.read_word = req.read_word;
    unique case (req.req_type)
      REQ_START: decoded.op = OP_START;
      REQ_FILL:  decoded.op = OP_FILL;
      REQ_CHECK: decoded.op = OP_CHECK;
      default:   decoded.op = OP_BAD;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hdl/mrpt_back.sv
// Back end: pattern generator, phase sequencer and the result queue.
// Depends on mrpt_pkg; fed by mrpt_front.
module mrpt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mrpt_pkg::COUNT_W-1:0]    cfg_data,
  input  mrpt_pkg::cmd_t                  cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  output logic                            empty,
  input  logic                            pop,
  output mrpt_pkg::rsp_t                  rsp
);
  import mrpt_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FILL  = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  logic [COUNT_W-1:0] eff_count;
  logic [GEN_W-1:0]   generator, generator_next;
  logic [GEN_W-1:0]   saved_seed, saved_seed_next;
  logic [COUNT_W-1:0] word_index, word_index_next;
  logic [1:0]         phase, phase_next;
  logic [GEN_W-1:0]   gen_stepped;
  logic [COUNT_W-1:0] index_inc;
  logic               last_word;
  rsp_t               result;

  rsp_t       out_mem [2];
  logic       out_wr;
  logic       out_rd;
  logic [1:0] out_count;
  logic       out_pop;
  logic       exec;

  assign gen_stepped = generator[GEN_W-1] ? (generator << 1)
                                          : ((generator << 1) ^ GEN_TAPS);
  assign index_inc = word_index + COUNT_W'(1);
  assign last_word = (index_inc >= eff_count);

  assign out_pop = pop && !empty;
  assign exec    = cmd_valid && ((out_count != 2'd2) || out_pop);
  assign cmd_pop = exec;

  always_comb begin
    generator_next  = generator;
    saved_seed_next = saved_seed;
    word_index_next = word_index;
    phase_next      = phase;
    result          = '{KIND_IGNORED, '0, '0};
    if (cmd.op == OP_START) begin
      saved_seed_next = generator;
      word_index_next = '0;
      phase_next      = PH_FILL;
      result          = '{KIND_STARTED, '0, '0};
    end else if (cmd.op == OP_FILL && phase == PH_FILL) begin
      generator_next  = gen_stepped;
      word_index_next = index_inc;
      result          = '{KIND_WRITE, {word_index, 1'b0}, gen_stepped[15:0]};
      if (last_word) begin
        generator_next  = saved_seed;
        word_index_next = '0;
        phase_next      = PH_CHECK;
      end
    end else if (cmd.op == OP_CHECK && phase == PH_CHECK) begin
      generator_next = gen_stepped;
      if (cmd.read_word != gen_stepped[15:0]) begin
        phase_next = PH_IDLE;
        result     = '{KIND_MISMATCH, {word_index, 1'b0}, gen_stepped[15:0]};
      end else begin
        word_index_next = index_inc;
        if (last_word) begin
          phase_next = PH_IDLE;
          result     = '{KIND_PASS, {eff_count, 1'b0}, gen_stepped[15:0]};
        end else begin
          result     = '{KIND_MATCH, {word_index, 1'b0}, gen_stepped[15:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_count  <= COUNT_RESET;
      generator  <= GEN_RESET;
      saved_seed <= '0;
      word_index <= '0;
      phase      <= PH_IDLE;
    end else begin
      if (cfg_we) begin
        // clamp to 1 .. 2^WORD_INDEX_BITS once at write time
        if (cfg_data == '0) begin
          eff_count <= COUNT_W'(1);
        end else if (cfg_data > COUNT_LIMIT) begin
          eff_count <= COUNT_LIMIT;
        end else begin
          eff_count <= cfg_data;
        end
      end
      if (exec) begin
        generator  <= generator_next;
        saved_seed <= saved_seed_next;
        word_index <= word_index_next;
        phase      <= phase_next;
      end
    end
  end

  assign empty = (out_count == 2'd0);
  assign rsp   = out_mem[out_rd];

  always_ff @(posedge clk) begin
    if (exec) begin
      out_mem[out_wr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (exec) begin
        out_wr <= ~out_wr;
      end
      if (out_pop) begin
        out_rd <= ~out_rd;
      end
      out_count <= out_count + {1'b0, exec} - {1'b0, out_pop};
    end
  end

endmodule

// File: hdl/memory_random_pattern_test_core.sv
// Memory random pattern test core: top level joining front and back ends.
// Depends on mrpt_pkg, mrpt_front and mrpt_back.
//
// Self-test sequencer for a 16-bit memory region. Push a start request, then
// one fill request per word (each returns a write command with byte offset
// and pattern word), then one check request per word with the word read
// back; the core returns match, pass with the region size in bytes, or the
// first mismatch with its offset. Requests in the wrong phase come back as
// ignored. One request is taken per clock while the decode queue has room and
// one result leaves per clock while pop is high and results wait. A request is
// registered into the decode queue, then goes through the execute stage into
// the result queue, from which it can be popped; execution stalls while the
// result queue is full. The back end's generator step and index compare are
// combinational. The user must write word_count through cfg_valid/cfg_data
// only while no request is in flight; the core itself does not enforce this.
module memory_random_pattern_test_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  mrpt_pkg::req_t                req,
  output logic                          empty,
  input  logic                          pop,
  output mrpt_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrpt_pkg::COUNT_W-1:0]  cfg_data
);
  import mrpt_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;

  assign cfg_ready = 1'b1;

  mrpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mrpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_reset_clears : assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_kind_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.result_kind <= KIND_IGNORED))
    else $error("result kind out of range");

  a_offset_even : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.byte_offset[0] == 1'b0))
    else $error("odd byte offset");

  a_pass_nonzero : assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.result_kind == KIND_PASS) |-> (rsp.byte_offset != '0))
    else $error("pass reported with zero region size");
`endif

endmodule
